// ----- rtl/rtos_pkg.sv -----
// ----------------------------------------------------------------------------
// rtos_pkg
// Shared types, codes and elaboration helpers for the rectangle table search.
// ----------------------------------------------------------------------------
package rtos_pkg;

  localparam int RTOS_MAX_RECTS = 64;
  localparam int RTOS_RADIX     = 8;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_OVERLAP = 2'd2;
  localparam logic [1:0] OP_CONTAIN = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] tag;
  } rect_t;

  // For an overlap query the corners are already put in order.
  typedef struct packed {
    logic        overlap;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
  } query_t;

  typedef struct packed {
    logic live;
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Number of radix-8 reduction levels needed to bring n nodes down to one.
  function automatic int tree_levels(input int n);
    int c;
    int l;
    c = n;
    l = 0;
    for (int s = 0; s < 12; s++) begin
      if (c > 1) begin
        c = (c + RTOS_RADIX - 1) >> 3;
        l = l + 1;
      end
    end
    return l;
  endfunction

  // Number of nodes present at reduction level k.
  function automatic int level_count(input int n, input int k);
    int c;
    c = n;
    for (int s = 0; s < 12; s++) begin
      if (s < k) begin
        c = (c + RTOS_RADIX - 1) >> 3;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/rtos_cell.sv -----
// ----------------------------------------------------------------------------
// rtos_cell
// One table entry: holds a rectangle and its tag, appends, shifts down from
// its upper neighbor on remove, and compares itself against the query.
// ----------------------------------------------------------------------------
module rtos_cell
  import rtos_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  rect_t      add_data,
  input  rect_t      upper_data,
  input  query_t     query,
  output rect_t      data,
  output logic       hit
);

  logic overlap_hit;
  logic contain_hit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= add_data;
    end else if (ctrl.shift) begin
      data <= upper_data;
    end
  end

  assign overlap_hit = !(query.x1 > data.right || query.x2 < data.left ||
                         query.y1 > data.bottom || query.y2 < data.top);
  assign contain_hit = query.x1 >= data.left && query.x2 <= data.right &&
                       query.y1 >= data.top && query.y2 <= data.bottom;

  assign hit = ctrl.live && (query.overlap ? overlap_hit : contain_hit);

endmodule

// ----- rtl/rtos_tree.sv -----
// ----------------------------------------------------------------------------
// rtos_tree
// Registered radix-8 priority tree that picks the lowest-numbered hit cell
// and carries its position and tag to the root.
// ----------------------------------------------------------------------------
module rtos_tree
  import rtos_pkg::*;
#(
  parameter int COUNT = RTOS_MAX_RECTS,
  parameter int IW    = $clog2(RTOS_MAX_RECTS)
) (
  input  logic          clk,
  input  logic [COUNT-1:0] leaf_hit,
  input  logic [15:0]   leaf_tile [COUNT],
  output logic          root_hit,
  output logic [IW-1:0] root_index,
  output logic [15:0]   root_tile
);

  localparam int TL = tree_levels(COUNT);

  logic          node_hit   [TL+1][COUNT];
  logic [IW-1:0] node_index [TL+1][COUNT];
  logic [15:0]   node_tile  [TL+1][COUNT];

  for (genvar g = 0; g < COUNT; g++) begin : g_leaf
    assign node_hit[0][g]   = leaf_hit[g];
    assign node_index[0][g] = IW'(g);
    assign node_tile[0][g]  = leaf_tile[g];
  end

  for (genvar k = 1; k <= TL; k++) begin : g_level
    localparam int NODES = level_count(COUNT, k);
    localparam int CHILD = level_count(COUNT, k - 1);
    for (genvar g = 0; g < NODES; g++) begin : g_node
      logic          cand_hit   [RTOS_RADIX];
      logic [IW-1:0] cand_index [RTOS_RADIX];
      logic [15:0]   cand_tile  [RTOS_RADIX];
      logic          sel_hit;
      logic [IW-1:0] sel_index;
      logic [15:0]   sel_tile;

      for (genvar j = 0; j < RTOS_RADIX; j++) begin : g_child
        if (RTOS_RADIX * g + j < CHILD) begin : g_real
          assign cand_hit[j]   = node_hit[k-1][RTOS_RADIX*g+j];
          assign cand_index[j] = node_index[k-1][RTOS_RADIX*g+j];
          assign cand_tile[j]  = node_tile[k-1][RTOS_RADIX*g+j];
        end else begin : g_none
          assign cand_hit[j]   = 1'b0;
          assign cand_index[j] = '0;
          assign cand_tile[j]  = '0;
        end
      end

      // Walk from the top child down so the lowest hit wins.
      always_comb begin
        sel_hit   = 1'b0;
        sel_index = '0;
        sel_tile  = '0;
        for (int j = RTOS_RADIX - 1; j >= 0; j--) begin
          if (cand_hit[j]) begin
            sel_hit   = 1'b1;
            sel_index = cand_index[j];
            sel_tile  = cand_tile[j];
          end
        end
      end

      always_ff @(posedge clk) begin
        node_hit[k][g]   <= sel_hit;
        node_index[k][g] <= sel_index;
        node_tile[k][g]  <= sel_tile;
      end
    end
  end

  assign root_hit   = node_hit[TL][0];
  assign root_index = node_index[TL][0];
  assign root_tile  = node_tile[TL][0];

endmodule

// ----- rtl/rectangle_table_overlap_search.sv -----
// ----------------------------------------------------------------------------
// rectangle_table_overlap_search
// Ordered rectangle table with add, remove, overlap and containment search.
// ----------------------------------------------------------------------------
// Each table entry lives in its own cell, and all cells compare against a
// query at once; a registered radix-8 priority tree then picks the first hit.
// One request is handled at a time: the request register captures it, the
// cells compare against it, each level of the priority tree registers the
// pick, and the result is loaded into the output register. The input is
// ready again in the cycle the result appears, so a new request is not
// taken before the last one is through. Remove shifts every later cell
// down by one at once. A finished result sits in the output register, so
// the next request is taken while it waits.
module rectangle_table_overlap_search
  import rtos_pkg::*;
#(
  parameter int MAX_RECTS = RTOS_MAX_RECTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rect_left, rect_top, rect_right, rect_bottom, tile_tag, entry_index, pad
  input  logic [87:0] s_axis_tdata,
  // op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // match_position, match_tile, entry_count, pad
  output logic [31:0] m_axis_tdata,
  // status, found
  output logic [2:0]  m_axis_tuser
);

  localparam int IW   = $clog2(MAX_RECTS);
  localparam int CW   = $clog2(MAX_RECTS + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int TL   = tree_levels(MAX_RECTS);
  localparam int CNW  = $clog2(TL + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t         state;
  logic [CNW-1:0] cnt;
  logic [CW-1:0]  used_count;

  query_t      query;
  rect_t       add_data;
  logic [5:0]  entry_index;
  logic [1:0]  status;
  logic        do_add;
  logic        do_remove;
  logic        is_query;

  logic        accept;
  logic        run_first;
  logic [15:0] in_left;
  logic [15:0] in_top;
  logic [15:0] in_right;
  logic [15:0] in_bottom;
  logic [5:0]  in_index;
  logic [1:0]  in_op;
  query_t      query_next;

  rect_t          cell_data [MAX_RECTS];
  logic [MAX_RECTS-1:0] cell_hit;
  logic [15:0]    cell_tile [MAX_RECTS];

  logic           root_hit;
  logic [IW-1:0]  root_index;
  logic [15:0]    root_tile;
  logic [IW:0]    pos_full;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign run_first     = (state == S_RUN) && (cnt == '0);

  assign in_left   = s_axis_tdata[15:0];
  assign in_top    = s_axis_tdata[31:16];
  assign in_right  = s_axis_tdata[47:32];
  assign in_bottom = s_axis_tdata[63:48];
  assign in_index  = s_axis_tdata[85:80];
  assign in_op     = s_axis_tuser;

  always_comb begin
    query_next.overlap = (in_op == OP_OVERLAP);
    query_next.x1 = in_left;
    query_next.x2 = in_right;
    query_next.y1 = in_top;
    query_next.y2 = in_bottom;
    if (in_op == OP_OVERLAP) begin
      if (!(in_left < in_right)) begin
        query_next.x1 = in_right;
        query_next.x2 = in_left;
      end
      if (!(in_top < in_bottom)) begin
        query_next.y1 = in_bottom;
        query_next.y2 = in_top;
      end
    end
  end

  // Request capture; nothing else changes the table until this request ends.
  always_ff @(posedge clk) begin
    if (accept) begin
      query          <= query_next;
      add_data.left   <= in_left;
      add_data.top    <= in_top;
      add_data.right  <= in_right;
      add_data.bottom <= in_bottom;
      add_data.tag    <= s_axis_tdata[79:64];
      entry_index    <= in_index;
      do_add         <= (in_op == OP_ADD) && (used_count < CW'(MAX_RECTS));
      do_remove      <= (in_op == OP_REMOVE) && (CMPW'(in_index) < CMPW'(used_count));
      is_query       <= (in_op == OP_OVERLAP) || (in_op == OP_CONTAIN);
      status         <= ST_OK;
      if (in_op == OP_ADD && used_count >= CW'(MAX_RECTS)) begin
        status <= ST_FULL;
      end else if (in_op == OP_REMOVE && CMPW'(in_index) >= CMPW'(used_count)) begin
        status <= ST_BAD_INDEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      used_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            cnt   <= '0;
          end
        end
        S_RUN: begin
          if (run_first) begin
            if (do_add) begin
              used_count <= used_count + CW'(1);
            end else if (do_remove) begin
              used_count <= used_count - CW'(1);
            end
          end
          if (cnt == CNW'(TL - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + CNW'(1);
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    rect_t      upper;

    assign ctrl.live  = CW'(i) < used_count;
    assign ctrl.load  = run_first && do_add && (used_count == CW'(i));
    assign ctrl.shift = run_first && do_remove && (CMPW'(i) >= CMPW'(entry_index));

    if (i + 1 < MAX_RECTS) begin : g_mid
      assign upper = cell_data[i+1];
    end else begin : g_end
      assign upper = cell_data[i];
    end

    rtos_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .add_data   (add_data),
      .upper_data (upper),
      .query      (query),
      .data       (cell_data[i]),
      .hit        (cell_hit[i])
    );

    assign cell_tile[i] = cell_data[i].tag;
  end

  rtos_tree #(
    .COUNT (MAX_RECTS),
    .IW    (IW)
  ) u_tree (
    .clk        (clk),
    .leaf_hit   (cell_hit),
    .leaf_tile  (cell_tile),
    .root_hit   (root_hit),
    .root_index (root_index),
    .root_tile  (root_tile)
  );

  assign pos_full = (IW + 1)'(root_index) + (IW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser[1:0]   <= status;
      m_axis_tuser[2]     <= is_query && root_hit;
      m_axis_tdata[6:0]   <= (is_query && root_hit) ? 7'(pos_full) : 7'd0;
      m_axis_tdata[22:7]  <= (is_query && root_hit) ? root_tile : 16'd0;
      m_axis_tdata[29:23] <= 7'(used_count);
      m_axis_tdata[31:30] <= 2'd0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(MAX_RECTS))
    else $error("entry count exceeds table size");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN)
    else $error("accepted request did not start");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_DONE))
    else $error("result appeared without a finished request");

endmodule
